// ===== rtl/rpfl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rpfl_pkg;

	localparam int PAGE_COUNT = 64;
	localparam int PAGE_W     = 6;
	localparam int LINK_W     = $clog2(PAGE_COUNT + 1);
	localparam int CNT_W      = 8;
	localparam int FREE_W     = 7;

	localparam logic [LINK_W-1:0] NO_PAGE   = LINK_W'(PAGE_COUNT);
	localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_ADD_REF = 2'd2,
		OP_QUERY   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_FREE = 2'd1,
		ST_CNT_ERR = 2'd2
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic accept;   // latch request, launch table reads
		logic commit;   // apply update, load result register
	} cmd_t;

endpackage
`default_nettype wire

// ===== rtl/rpfl_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rpfl_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  wire logic         out_stall,
	output rpfl_pkg::cmd_t    cmd
);
	import rpfl_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign cmd.accept = in_valid && (state_q == S_IDLE);
	// result register must be empty or draining before it is overwritten
	assign cmd.commit = (state_q == S_EXEC) && !(out_valid_q && out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (out_valid_q && !out_stall)
						out_valid_q <= 1'b0;
					if (cmd.accept)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (cmd.commit) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q     <= S_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	a_commit_not_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(out_valid_q && out_stall))
		else $error("commit while result word still held");

	a_accept_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == S_EXEC))
		else $error("accepted word did not enter execute");

	a_commit_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (out_valid_q && state_q == S_IDLE))
		else $error("commit did not present a result word");

endmodule
`default_nettype wire

// ===== rtl/rpfl_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rpfl_dpath (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire rpfl_pkg::cmd_t               cmd,
	input  wire logic [1:0]                   opcode,
	input  wire logic [rpfl_pkg::PAGE_W-1:0]  page_index,
	output logic [rpfl_pkg::PAGE_W-1:0]       page_out,
	output logic [1:0]                        status,
	output logic [rpfl_pkg::CNT_W-1:0]        ref_count,
	output logic [rpfl_pkg::FREE_W-1:0]       free_pages
);
	import rpfl_pkg::*;

	// tables; an entry not yet written reads as its reset value
	logic [LINK_W-1:0]     nt_mem [PAGE_COUNT];
	logic [CNT_W-1:0]      rc_mem [PAGE_COUNT];
	logic [PAGE_COUNT-1:0] nt_vld_q;
	logic [PAGE_COUNT-1:0] rc_vld_q;

	logic [LINK_W-1:0] head_q;
	logic [FREE_W-1:0] free_q;

	opcode_t           op_q;
	logic [PAGE_W-1:0] pg_q;
	logic [LINK_W-1:0] nt_rd_q;
	logic              nt_rdv_q;
	logic [CNT_W-1:0]  rc_rd_q;
	logic              rc_rdv_q;

	logic [PAGE_W-1:0] page_out_q;
	status_t           status_q;
	logic [CNT_W-1:0]  ref_count_q;

	logic [PAGE_W-1:0] head_idx;
	logic [LINK_W-1:0] nt_val;
	logic [CNT_W-1:0]  rc_val;
	logic              in_range;

	logic              nt_we;
	logic [PAGE_W-1:0] nt_wa;
	logic [LINK_W-1:0] nt_wd;
	logic              rc_we;
	logic [PAGE_W-1:0] rc_wa;
	logic [CNT_W-1:0]  rc_wd;

	logic [LINK_W-1:0] head_nxt;
	logic [FREE_W-1:0] free_nxt;
	logic [PAGE_W-1:0] page_nxt;
	status_t           status_nxt;
	logic [CNT_W-1:0]  count_nxt;

	assign head_idx = head_q[PAGE_W-1:0];
	assign nt_val   = nt_rdv_q ? nt_rd_q : (head_q + LINK_W'(1));
	assign rc_val   = rc_rdv_q ? rc_rd_q : '0;
	assign in_range = (LINK_W'(pg_q) < LINK_W'(PAGE_COUNT));

	always_comb begin
		nt_we      = 1'b0;
		nt_wa      = pg_q;
		nt_wd      = NO_PAGE;
		rc_we      = 1'b0;
		rc_wa      = pg_q;
		rc_wd      = '0;
		head_nxt   = head_q;
		free_nxt   = free_q;
		page_nxt   = pg_q;
		status_nxt = ST_OK;
		count_nxt  = '0;
		case (op_q)
			OP_ALLOC: begin
				if (head_q >= LINK_W'(PAGE_COUNT)) begin
					status_nxt = ST_NO_FREE;
					page_nxt   = '0;
				end else begin
					head_nxt  = nt_val;
					nt_we     = 1'b1;
					nt_wa     = head_idx;
					nt_wd     = NO_PAGE;
					rc_we     = 1'b1;
					rc_wa     = head_idx;
					rc_wd     = CNT_W'(1);
					if (free_q != '0)
						free_nxt = free_q - FREE_W'(1);
					page_nxt  = head_idx;
					count_nxt = CNT_W'(1);
				end
			end
			OP_RELEASE: begin
				if (in_range) begin
					count_nxt = rc_val;
					if (rc_val == '0) begin
						status_nxt = ST_CNT_ERR;
					end else begin
						count_nxt = rc_val - CNT_W'(1);
						rc_we     = 1'b1;
						rc_wd     = rc_val - CNT_W'(1);
						// last reference gone: push page back on the list
						if (rc_val == CNT_W'(1)) begin
							nt_we    = 1'b1;
							nt_wd    = head_q;
							head_nxt = LINK_W'(pg_q);
							if (free_q < FREE_W'(PAGE_COUNT))
								free_nxt = free_q + FREE_W'(1);
						end
					end
				end
			end
			OP_ADD_REF: begin
				if (in_range) begin
					count_nxt = rc_val;
					// a free page must not gain a reference, and a full count must not wrap
					if (rc_val == '0 || rc_val == COUNT_MAX) begin
						status_nxt = ST_CNT_ERR;
					end else begin
						count_nxt = rc_val + CNT_W'(1);
						rc_we     = 1'b1;
						rc_wd     = rc_val + CNT_W'(1);
					end
				end
			end
			OP_QUERY: begin
				if (in_range)
					count_nxt = rc_val;
			end
			default: begin
				status_nxt = ST_OK;
			end
		endcase
	end

	// request latch and registered table reads
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q     <= opcode_t'(opcode);
			pg_q     <= page_index;
			nt_rd_q  <= nt_mem[head_idx];
			nt_rdv_q <= nt_vld_q[head_idx];
			rc_rd_q  <= rc_mem[page_index];
			rc_rdv_q <= rc_vld_q[page_index];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && nt_we)
			nt_mem[nt_wa] <= nt_wd;
		if (cmd.commit && rc_we)
			rc_mem[rc_wa] <= rc_wd;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			page_out_q  <= page_nxt;
			status_q    <= status_nxt;
			ref_count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nt_vld_q <= '0;
			rc_vld_q <= '0;
			head_q   <= '0;
			free_q   <= FREE_W'(PAGE_COUNT);
		end else if (cmd.commit) begin
			if (nt_we)
				nt_vld_q[nt_wa] <= 1'b1;
			if (rc_we)
				rc_vld_q[rc_wa] <= 1'b1;
			head_q <= head_nxt;
			free_q <= free_nxt;
		end
	end

	assign page_out   = page_out_q;
	assign status     = status_q;
	assign ref_count  = ref_count_q;
	assign free_pages = free_q;

	a_free_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= FREE_W'(PAGE_COUNT))
		else $error("free count above page count");

	a_empty_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q >= LINK_W'(PAGE_COUNT)) == (free_q == '0))
		else $error("list head and free count disagree");

	a_alloc_ok_count_one: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && op_q == OP_ALLOC && status_nxt == ST_OK)
		|=> (ref_count_q == CNT_W'(1)))
		else $error("allocated page count is not one");

endmodule
`default_nettype wire

// ===== rtl/refcounted_page_free_list_unit.sv =====
// An accepted word is latched with its table reads; in the execute state the update is
//   applied and the result register loaded, held back only while the result port stalls.
// A new word is taken only after the last one commits, set by the registered read of
//   the next-page and count tables before the list head can be updated.
// Reset (arst_n, async, active low): list holds every page in order, all counts
//   zero; per-entry valid bits make the tables usable at once, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module refcounted_page_free_list_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [1:0]                   opcode,
	input  wire logic [rpfl_pkg::PAGE_W-1:0]  page_index,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [rpfl_pkg::PAGE_W-1:0]       page_out,
	output logic [1:0]                        status,
	output logic [rpfl_pkg::CNT_W-1:0]        ref_count,
	output logic [rpfl_pkg::FREE_W-1:0]       free_pages
);
	import rpfl_pkg::*;

	cmd_t cmd;

	rpfl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	rpfl_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.opcode     (opcode),
		.page_index (page_index),
		.page_out   (page_out),
		.status     (status),
		.ref_count  (ref_count),
		.free_pages (free_pages)
	);

endmodule
`default_nettype wire
